@@ rtl/core/rbrt_pkg.sv @@
// Package for the refcounted buffer region table: transfer types, codes, cell interfaces.
// No dependencies; used by rbrt_cell and refcounted_buffer_region_table_core.
package rbrt_pkg;

  localparam int unsigned SlotsDefault = 32;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_REF  = 3'd1,
    OP_REL  = 3'd2,
    OP_LOOK = 3'd3,
    OP_RDH  = 3'd4,
    OP_RALL = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOENT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        slot_index;
    logic [63:0]        address;
    logic [39:0]        length;
    logic signed [31:0] handle_fd;
    logic [63:0]        map_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [39:0] offset;
    logic [30:0] fd_out;
    logic [63:0] map_tag_out;
    logic        released;
    logic        last;
    logic [31:0] generation;
    logic [6:0]  used_slots;
  } out_t;

  // broadcast command to every cell; wr/inc/dec act only on selected cells
  typedef struct packed {
    logic eval;
    logic wr;
    logic inc;
    logic dec;
    logic clr;
  } cell_cmd_t;

  // priority chain passed from cell to cell, lowest index first
  typedef struct packed {
    logic free_seen;
    logic hit_seen;
  } chain_t;

  typedef struct packed {
    logic        valid;
    logic        first_free;
    logic        first_hit;
    logic        over;
    logic        last_ref;
    logic [39:0] off;
    logic [30:0] handle;
    logic [63:0] tag;
  } cell_stat_t;

  function automatic logic [31:0] gen_next(input logic [31:0] g);
    logic [31:0] n;
    n = g + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

endpackage

@@ rtl/core/rbrt_cell.sv @@
// One slot of the region table: stored entry, reference count and range compare.
// Depends on rbrt_pkg; chained by the core through chain_i/chain_o.
module rbrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbrt_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  rbrt_pkg::in_t      req_i,
  input  rbrt_pkg::chain_t   chain_i,
  output rbrt_pkg::chain_t   chain_o,
  output rbrt_pkg::cell_stat_t stat_o
);
  import rbrt_pkg::*;

  logic        valid_q;
  logic [63:0] base_q;
  logic [39:0] size_q;
  logic [30:0] handle_q;
  logic [63:0] tag_q;
  logic [31:0] ref_q;
  logic        hit_q, over_q;
  logic [39:0] off_q;

  logic [63:0] diff;
  logic        in_range, over_d;

  assign diff     = req_i.address - base_q;
  assign in_range = (req_i.address >= base_q) && (diff < {24'd0, size_q});
  assign over_d   = ({1'b0, diff[39:0]} + {1'b0, req_i.length}) > {1'b0, size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clr) begin
      valid_q <= 1'b0;
    end else if (sel_i && cmd_i.wr) begin
      valid_q <= 1'b1;
    end else if (sel_i && cmd_i.dec && (ref_q == 32'd1)) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.wr) begin
      base_q   <= req_i.address;
      size_q   <= req_i.length;
      handle_q <= req_i.handle_fd[30:0];
      tag_q    <= req_i.map_tag;
      ref_q    <= 32'd1;
    end else if (sel_i && cmd_i.inc && (ref_q != 32'hFFFF_FFFF)) begin
      ref_q <= ref_q + 32'd1;
    end else if (sel_i && cmd_i.dec) begin
      ref_q <= ref_q - 32'd1;
    end
    if (cmd_i.eval) begin
      hit_q  <= in_range;
      over_q <= over_d;
      off_q  <= diff[39:0];
    end
  end

  assign chain_o.free_seen = chain_i.free_seen | ~valid_q;
  assign chain_o.hit_seen  = chain_i.hit_seen | (valid_q & hit_q);

  assign stat_o.valid      = valid_q;
  assign stat_o.first_free = ~valid_q & ~chain_i.free_seen;
  assign stat_o.first_hit  = valid_q & hit_q & ~chain_i.hit_seen;
  assign stat_o.over       = over_q;
  assign stat_o.last_ref   = (ref_q == 32'd1);
  assign stat_o.off        = off_q;
  assign stat_o.handle     = handle_q;
  assign stat_o.tag        = tag_q;

endmodule

@@ rtl/core/refcounted_buffer_region_table_core.sv @@
// Top level of the refcounted buffer region table: sequencer over a chain of slot cells.
// Depends on rbrt_pkg and rbrt_cell.
//
//  channel   | ports                        | transfer
//  ----------+------------------------------+----------------------------------
//  command   | start_i, busy_o, req_i       | edge with start_i high, busy_o low
//  result    | res_valid_o, res_o           | every cycle res_valid_o is high
//
// An item passes in order through accept, a registered range compare in every cell,
// then priority select and table write; its result shows the cycle after.
// Release-all then scans each live slot, one result per cycle from a snapshot.
// busy_o is low in the cycle the result shows, so the next command overlaps it.
// Reset clears slot valid bits, generation, high-water and live flag at once.
// The receiver cannot stall; results are never held.
module refcounted_buffer_region_table_core #(
  parameter int unsigned SLOTS = rbrt_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rbrt_pkg::in_t req_i,
  output logic          res_valid_o,
  output rbrt_pkg::out_t res_o
);
  import rbrt_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DONE = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  in_t         req_q;
  logic [31:0] cc_q, cc_d;
  logic [6:0]  hw_q, hw_d;
  logic        live_q, live_d;
  logic [SLOTS-1:0] mask_q, mask_d;
  out_t        res_q, res_d;
  logic        rv_q, rv_d;

  cell_cmd_t   cmd;
  logic [SLOTS-1:0] sel;
  chain_t      chain [SLOTS+1];
  cell_stat_t  stat [SLOTS];

  logic [SLOTS-1:0] valid_v, ff_v, fh_v, idx_oh, low_oh;

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rbrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel[g]),
      .req_i   (req_q),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .stat_o  (stat[g])
    );
    assign valid_v[g] = stat[g].valid;
    assign ff_v[g]    = stat[g].first_free;
    assign fh_v[g]    = stat[g].first_hit;
    assign idx_oh[g]  = (req_q.slot_index == 16'(g));
  end

  assign low_oh = mask_q & (~mask_q + SLOTS'(1));

  // one-hot selects over the cells
  logic [IW-1:0] ff_idx, fh_idx, sc_idx;
  logic [39:0]   fh_off;
  logic          fh_over, idx_last, idx_valid;
  logic [30:0]   idx_h, sc_h;
  logic [63:0]   idx_t, sc_t;

  always_comb begin
    ff_idx = '0; fh_idx = '0; sc_idx = '0;
    fh_off = '0; fh_over = 1'b0; idx_last = 1'b0; idx_valid = 1'b0;
    idx_h = '0; sc_h = '0; idx_t = '0; sc_t = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (ff_v[j]) ff_idx |= IW'(j);
      if (fh_v[j]) begin
        fh_idx  |= IW'(j);
        fh_off  |= stat[j].off;
        fh_over |= stat[j].over;
      end
      if (idx_oh[j]) begin
        idx_valid |= stat[j].valid;
        idx_last  |= stat[j].last_ref;
        idx_h     |= stat[j].handle;
        idx_t     |= stat[j].tag;
      end
      if (low_oh[j]) begin
        sc_idx |= IW'(j);
        sc_h   |= stat[j].handle;
        sc_t   |= stat[j].tag;
      end
    end
  end

  logic idx_ok, present, bad_add;
  logic [31:0] cc_base;
  logic [6:0]  ff_hw;

  assign idx_ok  = (req_q.slot_index < 16'(SLOTS));
  assign present = idx_ok && idx_valid;
  assign bad_add = (req_q.address == 64'd0) || (req_q.length == 40'd0) || req_q.handle_fd[31];
  assign cc_base = live_q ? cc_q : 32'd1;
  assign ff_hw   = 7'(ff_idx) + 7'd1;

  always_comb begin
    state_d = state_q;
    cc_d    = cc_q;
    hw_d    = hw_q;
    live_d  = live_q;
    mask_d  = mask_q;
    cmd     = '0;
    sel     = '0;
    res_d   = '0;
    rv_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d      = S_IDLE;
        rv_d         = 1'b1;
        res_d.last   = 1'b1;
        res_d.status = ST_OK;
        unique case (opcode_e'(req_q.opcode))
          OP_ADD: begin
            if (bad_add) begin
              res_d.status = ST_INVAL;
            end else begin
              live_d = 1'b1;
              cc_d   = cc_base;
              if (!(|ff_v)) begin
                res_d.status = ST_FULL;
              end else begin
                cmd.wr = 1'b1;
                sel    = ff_v;
                if (ff_hw > hw_q) hw_d = ff_hw;
                cc_d           = gen_next(cc_base);
                res_d.slot_out = 6'(ff_idx);
              end
            end
          end
          OP_REF: begin
            if (!present) begin
              res_d.status = ST_NOENT;
            end else begin
              cmd.inc = 1'b1;
              sel     = idx_oh;
            end
          end
          OP_REL: begin
            if (!present) begin
              res_d.status = ST_NOENT;
            end else begin
              cmd.dec        = 1'b1;
              sel            = idx_oh;
              res_d.slot_out = req_q.slot_index[5:0];
              if (idx_last) begin
                res_d.released    = 1'b1;
                res_d.fd_out      = idx_h;
                res_d.map_tag_out = idx_t;
                cc_d              = gen_next(cc_q);
              end
            end
          end
          OP_LOOK: begin
            if (!(|fh_v)) begin
              res_d.status = ST_NOENT;
            end else if (fh_over) begin
              res_d.status = ST_INVAL;
            end else begin
              res_d.slot_out = 6'(fh_idx);
              res_d.offset   = fh_off;
            end
          end
          OP_RDH: begin
            if (!idx_ok) res_d.status = ST_INVAL;
            else if (!idx_valid) res_d.status = ST_NOENT;
            else res_d.fd_out = idx_h;
          end
          OP_RALL: begin
            cmd.clr = 1'b1;
            cc_d    = '0;
            hw_d    = '0;
            live_d  = 1'b0;
            if (|valid_v) begin
              mask_d  = valid_v;
              rv_d    = 1'b0;
              state_d = S_SCAN;
            end else begin
              res_d.status = live_q ? ST_OK : ST_NOENT;
            end
          end
          default: res_d.status = ST_INVAL;
        endcase
        res_d.generation = cc_d;
        res_d.used_slots = hw_d;
      end
      S_SCAN: begin
        rv_d              = 1'b1;
        res_d.status      = ST_OK;
        res_d.slot_out    = 6'(sc_idx);
        res_d.fd_out      = sc_h;
        res_d.map_tag_out = sc_t;
        res_d.released    = 1'b1;
        mask_d            = mask_q & ~low_oh;
        res_d.last        = (mask_d == '0);
        if (mask_d == '0) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cc_q    <= '0;
      hw_q    <= '0;
      live_q  <= 1'b0;
      mask_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      hw_q    <= hw_d;
      live_q  <= live_d;
      mask_q  <= mask_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) req_q <= req_i;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // at most one cell claims the first free slot and the first hit
  a_ff_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(ff_v))
    else $error("more than one first free cell");
  a_fh_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> $onehot0(fh_v))
    else $error("more than one first hit cell");
  a_scan_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> ($countones(mask_q) + 1 == $countones($past(mask_q))))
    else $error("scan did not retire exactly one slot");
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == S_DONE || $past(state_q) == S_SCAN))
    else $error("result without a deciding cycle");

endmodule

@@ sim/tb.sv @@
// Testbench for refcounted_buffer_region_table_core: directed and random region table commands.
// Depends on rbrt_pkg and the core; holds its own table predictor in a scoreboard class.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbrt_pkg::*;

  localparam int unsigned NSLOT = 32;
  localparam int unsigned QUIET_LIMIT = 2000;

  class region_table_sb;
    bit          live;
    bit          valid [NSLOT];
    bit [63:0]   base [NSLOT];
    bit [39:0]   size [NSLOT];
    bit [30:0]   handle [NSLOT];
    bit [63:0]   tag [NSLOT];
    bit [31:0]   refs [NSLOT];
    bit [31:0]   gen;
    bit [6:0]    hwm;
    out_t        pending[$];
    int          errors;

    function void clear_all();
      live = 0;
      gen = 0;
      hwm = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function bit [31:0] bump(bit [31:0] g);
      bit [31:0] n;
      n = g + 1;
      return (n == 0) ? 32'd1 : n;
    endfunction

    function void push(status_e st, int sl, bit [39:0] off, bit [30:0] fd,
                       bit [63:0] tg, bit rel);
      out_t r;
      r = '0;
      r.status = st;
      r.slot_out = sl[5:0];
      r.offset = off;
      r.fd_out = fd;
      r.map_tag_out = tg;
      r.released = rel;
      r.generation = gen;
      r.used_slots = hwm;
      pending.push_back(r);
    endfunction

    function void note_command(in_t c);
      int i, n, first;
      bit present, found;
      bit [63:0] off;
      bit [30:0] h [NSLOT];
      bit [63:0] t [NSLOT];
      bit v [NSLOT];
      bit was_live;
      int hw0;
      first = pending.size();
      present = live && c.slot_index < hwm && c.slot_index < NSLOT && valid[c.slot_index];
      case (c.opcode)
        OP_ADD: begin
          if (c.address == 0 || c.length == 0 || c.handle_fd < 0) begin
            push(ST_INVAL, 0, 0, 0, 0, 0);
          end else begin
            if (!live) begin
              live = 1;
              gen = 1;
            end
            for (i = 0; i < NSLOT; i++) if (!valid[i]) break;
            if (i == NSLOT) push(ST_FULL, 0, 0, 0, 0, 0);
            else begin
              valid[i] = 1;
              base[i] = c.address;
              size[i] = c.length;
              handle[i] = c.handle_fd[30:0];
              tag[i] = c.map_tag;
              refs[i] = 1;
              if (i >= hwm) hwm = i + 1;
              gen = bump(gen);
              push(ST_OK, i, 0, 0, 0, 0);
            end
          end
        end
        OP_REF: begin
          if (!present) push(ST_NOENT, 0, 0, 0, 0, 0);
          else begin
            if (refs[c.slot_index] != 32'hFFFF_FFFF) refs[c.slot_index]++;
            push(ST_OK, 0, 0, 0, 0, 0);
          end
        end
        OP_REL: begin
          if (!present) push(ST_NOENT, 0, 0, 0, 0, 0);
          else begin
            refs[c.slot_index]--;
            if (refs[c.slot_index] != 0) push(ST_OK, c.slot_index, 0, 0, 0, 0);
            else begin
              valid[c.slot_index] = 0;
              gen = bump(gen);
              push(ST_OK, c.slot_index, 0, handle[c.slot_index], tag[c.slot_index], 1);
            end
          end
        end
        OP_LOOK: begin
          found = 0;
          if (live) begin
            for (i = 0; i < hwm && i < NSLOT; i++) begin
              if (!valid[i] || c.address < base[i]) continue;
              off = c.address - base[i];
              if (off >= {24'd0, size[i]}) continue;
              found = 1;
              if (off + {24'd0, c.length} > {24'd0, size[i]}) push(ST_INVAL, 0, 0, 0, 0, 0);
              else push(ST_OK, i, off[39:0], 0, 0, 0);
              break;
            end
          end
          if (!found) push(ST_NOENT, 0, 0, 0, 0, 0);
        end
        OP_RDH: begin
          if (c.slot_index >= NSLOT) push(ST_INVAL, 0, 0, 0, 0, 0);
          else if (!live || !valid[c.slot_index]) push(ST_NOENT, 0, 0, 0, 0, 0);
          else push(ST_OK, 0, 0, handle[c.slot_index], 0, 0);
        end
        OP_RALL: begin
          was_live = live;
          hw0 = hwm;
          foreach (v[k]) begin
            v[k] = valid[k];
            h[k] = handle[k];
            t[k] = tag[k];
          end
          clear_all();
          n = 0;
          if (was_live)
            for (i = 0; i < hw0 && i < NSLOT; i++)
              if (v[i]) begin
                push(ST_OK, i, 0, h[i], t[i], 1);
                n++;
              end
          if (n == 0) push(was_live ? ST_OK : ST_NOENT, 0, 0, 0, 0, 0);
        end
        default: push(ST_INVAL, 0, 0, 0, 0, 0);
      endcase
      pending[pending.size()-1].last = 1;
    endfunction

    task report(string what, out_t got, out_t exp);
      $display("mismatch %s: got %p expected %p", what, got, exp);
      errors++;
    endtask

    task check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) report("status", got, e);
      if (got.slot_out != e.slot_out) report("slot_out", got, e);
      if (got.offset != e.offset) report("offset", got, e);
      if (got.fd_out != e.fd_out) report("fd_out", got, e);
      if (got.map_tag_out != e.map_tag_out) report("map_tag_out", got, e);
      if (got.released != e.released) report("released", got, e);
      if (got.last != e.last) report("last", got, e);
      if (got.generation != e.generation) report("generation", got, e);
      if (got.used_slots != e.used_slots) report("used_slots", got, e);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  in_t  req_i = '0;
  logic res_valid_o;
  out_t res_o;

  region_table_sb tracker = new();
  int quiet = 0;
  bit [63:0] bases [$];

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  refcounted_buffer_region_table_core i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) tracker.check_result(res_o);
    if (rst_ni && (res_valid_o || (start_i && !busy_o))) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // the block stays busy after a transfer until it returns to idle, and the task waits for that
  task automatic issue(in_t c);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk_i);
    req_i <= c;
    start_i <= 1;
    do @(posedge clk_i); while (busy_o);
    tracker.note_command(c);
    start_i <= 0;
  endtask

  function automatic in_t mk(opcode_e op, int idx, bit [63:0] a, bit [39:0] l,
                             bit [31:0] fd, bit [63:0] tg);
    in_t c;
    c.opcode = op;
    c.slot_index = idx[15:0];
    c.address = a;
    c.length = l;
    c.handle_fd = fd;
    c.map_tag = tg;
    return c;
  endfunction

  // mostly small regions on 64 page-aligned bases so lookups hit
  function automatic in_t rand_cmd();
    in_t c;
    int r;
    bit [63:0] a;
    bit [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[218:0];
    r = $urandom_range(0, 99);
    c.slot_index = ($urandom_range(0, 9) == 0) ? c.slot_index : 16'($urandom_range(0, 35));
    if (r < 35) begin
      c.opcode = OP_ADD;
      if ($urandom_range(0, 9) != 0) begin
        a = {32'h0, 20'($urandom_range(1, 64)), 12'h0};
        c.address = a;
        c.length = 40'($urandom_range(1, 4096));
        c.handle_fd[31] = 0;
      end
    end else if (r < 50) c.opcode = OP_REF;
    else if (r < 70) c.opcode = OP_REL;
    else if (r < 85) begin
      c.opcode = OP_LOOK;
      if ($urandom_range(0, 4) != 0) begin
        c.address = {32'h0, 20'($urandom_range(1, 64)), 12'($urandom)};
        c.length = 40'($urandom_range(0, 4096));
      end
    end else if (r < 95) c.opcode = OP_RDH;
    else if (r < 98) c.opcode = OP_RALL;
    else c.opcode = opcode_e'($urandom_range(6, 7));
    return c;
  endfunction

  initial begin
    int k;
    tracker.clear_all();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: no table, bad args, extremes, bad opcode, full table
    issue(mk(OP_REF, 0, 0, 0, 0, 0));
    issue(mk(OP_RDH, 65535, 0, 0, 0, 0));
    issue(mk(OP_RDH, 3, 0, 0, 0, 0));
    issue(mk(OP_LOOK, 0, 64'h1000, 1, 0, 0));
    issue(mk(OP_RALL, 0, 0, 0, 0, 0));
    issue(mk(OP_ADD, 0, 0, 5, 3, 0));
    issue(mk(OP_ADD, 0, 64'h10, 0, 3, 0));
    issue(mk(OP_ADD, 0, 64'h10, 5, 32'h8000_0000, 0));
    issue(mk(OP_ADD, 0, 64'hFFFF_FFFF_FFFF_F000, 40'hFF_FFFF_FFFF, 32'h7FFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF));
    issue(mk(OP_ADD, 0, 64'h1, 40'h100, 0, 0));
    issue(mk(OP_LOOK, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0));
    issue(mk(OP_LOOK, 0, 64'h80, 40'h81, 0, 0));
    issue(mk(OP_LOOK, 0, 64'h80, 40'h81 - 1, 0, 0));
    issue(mk(OP_REF, 1, 0, 0, 0, 0));
    issue(mk(OP_REL, 1, 0, 0, 0, 0));
    issue(mk(OP_REL, 1, 0, 0, 0, 0));
    issue(mk(OP_REL, 1, 0, 0, 0, 0));
    issue(mk(OP_RDH, 0, 0, 0, 0, 0));
    issue(mk(OP_ADD, 0, 0, 0, 0, 0) ^ {3'd6, 216'd0});
    for (k = 0; k < 33; k++)
      issue(mk(OP_ADD, 0, 64'h100 * (k + 1), 40'h80, 32'(k), 64'(k)));
    issue(mk(OP_RALL, 0, 0, 0, 0, 0));
    issue(mk(OP_RALL, 0, 0, 0, 0, 0));
    for (k = 0; k < 205; k++) issue(rand_cmd());
    k = 0;
    while (tracker.pending.size() != 0 && k < QUIET_LIMIT) begin
      @(posedge clk_i);
      k++;
    end
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
